FILE: sv/dkdlp_pkg.sv
// Package for the two-key debounce and long-press block.
// Holds the key counts, field widths, reset values and register indexes.
// Depends on nothing; used by dual_key_debounce_long_press.
package dkdlp_pkg;

    localparam int NUM_KEYS   = 2;
    localparam int FIELD_KEYS = 2;
    localparam int SERVED_KEYS = (NUM_KEYS < FIELD_KEYS) ? NUM_KEYS : FIELD_KEYS;

    localparam int TIME_W     = 32;
    localparam int DEBOUNCE_W = 16;
    localparam int LONG_W     = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 1;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET   = 16'd20;
    localparam logic [LONG_W-1:0]     LONG_PRESS_RESET = 32'd2000;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_DEBOUNCE_MS   = 1'b0;
    localparam t_cfg_idx CFG_LONG_PRESS_MS = 1'b1;

    typedef logic [TIME_W-1:0] t_time;
    typedef logic [FIELD_KEYS-1:0] t_key_vec;

endpackage

FILE: sv/dual_key_debounce_long_press.sv
// Top level of the two-key debounce and long-press block.
// Holds the input register, per-key state, the event logic and the result register.
// Depends on dkdlp_pkg.
//
// Usage: each input word is a poll carrying a millisecond timestamp and the raw
// levels of two active-low keys. It is accepted when i_valid is high and o_stall
// is low. Each accepted poll yields exactly one result word with the press and
// long-press events of both keys, delivered when o_valid is high and i_stall low.
// Configuration writes (debounce time, long-press time) take effect at the edge
// where i_cfg_we is high and must only be made while the block is idle.
// An accepted poll is registered in the input register and then moves into the
// result register, raising o_valid, with the key state updated at that same edge.
// The move waits while the receiver stalls. Throughput is one poll per cycle
// while the receiver does not stall.
// While the receiver stalls, the result register holds and one further poll may
// wait in the input register; o_stall then rises until the result is taken.
// Reset clears both registers' valid flags, loads the default times and puts
// every key into the released state with zero timestamps.
module dual_key_debounce_long_press (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [dkdlp_pkg::TIME_W-1:0]       i_now_ms,
    input  logic                               i_key1_level,
    input  logic                               i_key2_level,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic                               o_key1_pressed,
    output logic                               o_key2_pressed,
    output logic                               o_key1_long,
    output logic                               o_key2_long,
    input  logic                               i_cfg_we,
    input  logic [dkdlp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dkdlp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    logic [dkdlp_pkg::DEBOUNCE_W-1:0] r_debounce_ms;
    logic [dkdlp_pkg::LONG_W-1:0]     r_long_press_ms;

    logic                    r_in_valid;
    dkdlp_pkg::t_time        r_in_now;
    dkdlp_pkg::t_key_vec     r_in_level;

    dkdlp_pkg::t_key_vec     r_last_level,   n_last_level;
    dkdlp_pkg::t_key_vec     r_stable_level, n_stable_level;
    dkdlp_pkg::t_key_vec     r_long_rep,     n_long_rep;
    dkdlp_pkg::t_time        r_change_time [dkdlp_pkg::FIELD_KEYS];
    dkdlp_pkg::t_time        n_change_time [dkdlp_pkg::FIELD_KEYS];
    dkdlp_pkg::t_time        r_press_time  [dkdlp_pkg::FIELD_KEYS];
    dkdlp_pkg::t_time        n_press_time  [dkdlp_pkg::FIELD_KEYS];

    dkdlp_pkg::t_key_vec     n_pressed, n_long;
    logic                    r_out_valid;
    dkdlp_pkg::t_key_vec     r_out_pressed, r_out_long;

    logic advance;
    logic in_load;

    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;
    assign in_load = i_valid && !o_stall;

    always_comb begin
        dkdlp_pkg::t_time elapsed;
        logic             changed;
        logic             settle;
        elapsed        = '0;
        changed        = 1'b0;
        settle         = 1'b0;
        n_last_level   = r_last_level;
        n_stable_level = r_stable_level;
        n_long_rep     = r_long_rep;
        n_change_time  = r_change_time;
        n_press_time   = r_press_time;
        n_pressed      = '0;
        n_long         = '0;
        for (int k = 0; k < dkdlp_pkg::SERVED_KEYS; k++) begin
            changed = (r_in_level[k] != r_last_level[k]);
            if (changed) begin
                n_last_level[k]  = r_in_level[k];
                n_change_time[k] = r_in_now;
                elapsed          = '0;
            end else begin
                elapsed = r_in_now - r_change_time[k];
            end
            settle = (elapsed >= dkdlp_pkg::TIME_W'(r_debounce_ms)) &&
                     (r_stable_level[k] != n_last_level[k]);
            if (settle) begin
                n_stable_level[k] = n_last_level[k];
                n_long_rep[k]     = 1'b0;
                if (!n_last_level[k]) begin
                    n_pressed[k]    = 1'b1;
                    n_press_time[k] = r_in_now;
                end else begin
                    n_press_time[k] = '0;
                end
            end
            elapsed = settle ? '0 : (r_in_now - r_press_time[k]);
            if (!n_stable_level[k] && !n_long_rep[k] && (elapsed >= r_long_press_ms)) begin
                n_long[k]     = 1'b1;
                n_long_rep[k] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms   <= dkdlp_pkg::DEBOUNCE_RESET;
            r_long_press_ms <= dkdlp_pkg::LONG_PRESS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                dkdlp_pkg::CFG_DEBOUNCE_MS: begin
                    r_debounce_ms <= i_cfg_data[dkdlp_pkg::DEBOUNCE_W-1:0];
                end
                dkdlp_pkg::CFG_LONG_PRESS_MS: begin
                    r_long_press_ms <= i_cfg_data[dkdlp_pkg::LONG_W-1:0];
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_in_now   <= i_now_ms;
            r_in_level <= {i_key2_level, i_key1_level};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_level   <= '1;
            r_stable_level <= '1;
            r_long_rep     <= '0;
            for (int k = 0; k < dkdlp_pkg::FIELD_KEYS; k++) begin
                r_change_time[k] <= '0;
                r_press_time[k]  <= '0;
            end
        end else if (advance) begin
            r_last_level   <= n_last_level;
            r_stable_level <= n_stable_level;
            r_long_rep     <= n_long_rep;
            r_change_time  <= n_change_time;
            r_press_time   <= n_press_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_pressed <= n_pressed;
            r_out_long    <= n_long;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_key1_pressed = r_out_pressed[0];
    assign o_key2_pressed = r_out_pressed[1];
    assign o_key1_long    = r_out_long[0];
    assign o_key2_long    = r_out_long[1];

endmodule
